// ===== rtl/core/segx_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segx_pkg
// Widths and pipeline payload types shared by the segment intersection unit.
// ----------------------------------------------------------------------------
package segx_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 16;
    localparam int POINT_BITS = 32;
    // Differences of coordinates, their products and the cross products.
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS  = 2 * DIFF_BITS;
    localparam int CROSS_BITS = PROD_BITS + 1;
    localparam int MUL_BITS   = DIFF_BITS + FRAC_BITS + 1;
    localparam int IN_BITS    = 8 * COORD_BITS;
    localparam int IN_BYTES   = (IN_BITS + 7) / 8;

    // Listed from the highest bits down, so that ax sits in the lowest bits
    // of an input transfer.
    typedef struct packed {
        logic signed [COORD_BITS-1:0] dy;
        logic signed [COORD_BITS-1:0] dx;
        logic signed [COORD_BITS-1:0] cy;
        logic signed [COORD_BITS-1:0] cx;
        logic signed [COORD_BITS-1:0] by;
        logic signed [COORD_BITS-1:0] bx;
        logic signed [COORD_BITS-1:0] ay;
        logic signed [COORD_BITS-1:0] ax;
    } seg_pair_t;

    // Payload passed along the divider chain.
    typedef struct packed {
        logic                         valid;
        logic                         hit;
        logic                         par;
        logic signed [COORD_BITS-1:0] ax;
        logic signed [COORD_BITS-1:0] ay;
        logic signed [DIFF_BITS-1:0]  ux;
        logic signed [DIFF_BITS-1:0]  uy;
        logic [CROSS_BITS-1:0]        rem;
        logic [CROSS_BITS-1:0]        den;
        logic [FRAC_BITS-1:0]         quo;
    } div_t;

endpackage

// ===== rtl/core/segment_intersection_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_intersection_unit
// Strict crossing test of two 2-D segments with the crossing point in Q16.16.
// ----------------------------------------------------------------------------
// The unit takes one segment pair in every cycle in which the pipeline is
// not held and returns one result for each pair, in order: four stages
// form the cross products and the crossing test, the quotient of the
// crossing parameter is produced one bit per stage by a chain of FRAC_BITS
// divider stages, and two stages scale and offset the point. The whole
// pipeline holds while a result waits on the output and the consumer is
// not ready.
module segment_intersection_unit
    import segx_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // first_start_x, first_start_y, first_end_x, first_end_y,
    // second_start_x, second_start_y, second_end_x, second_end_y
    input  logic [8*IN_BYTES-1:0] s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // point_x, point_y
    output logic [63:0]           m_tdata,
    // hit, parallel
    output logic [1:0]            m_tuser
);

    logic                         en;
    seg_pair_t                    pair;
    div_t                         chain [FRAC_BITS+1];
    logic                         hit, par;
    logic signed [POINT_BITS-1:0] px, py;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    assign pair.ax = s_tdata[0*COORD_BITS +: COORD_BITS];
    assign pair.ay = s_tdata[1*COORD_BITS +: COORD_BITS];
    assign pair.bx = s_tdata[2*COORD_BITS +: COORD_BITS];
    assign pair.by = s_tdata[3*COORD_BITS +: COORD_BITS];
    assign pair.cx = s_tdata[4*COORD_BITS +: COORD_BITS];
    assign pair.cy = s_tdata[5*COORD_BITS +: COORD_BITS];
    assign pair.dx = s_tdata[6*COORD_BITS +: COORD_BITS];
    assign pair.dy = s_tdata[7*COORD_BITS +: COORD_BITS];

    segx_cross u_cross (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_tvalid),
        .in_pair  (pair),
        .out_div  (chain[0])
    );

    for (genvar i = 0; i < FRAC_BITS; i++) begin : g_div
        segx_div_stage u_stage (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .in_div  (chain[i]),
            .out_div (chain[i+1])
        );
    end

    segx_point u_point (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_div    (chain[FRAC_BITS]),
        .out_valid (m_tvalid),
        .out_hit   (hit),
        .out_par   (par),
        .out_x     (px),
        .out_y     (py)
    );

    assign m_tdata = {py, px};
    assign m_tuser = {par, hit};

    a_hit_not_par: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(hit && par))
        else $error("hit and parallel both set");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !hit) |-> (px == '0 && py == '0))
        else $error("point not zero without a hit");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid straight after reset");

endmodule

// ===== rtl/core/segx_cross.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segx_cross
// Four stages: differences, products, cross products, then the crossing test
// and the magnitudes that seed the divider.
// ----------------------------------------------------------------------------
module segx_cross
    import segx_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      en,
    input  logic      in_valid,
    input  seg_pair_t in_pair,
    output div_t      out_div
);

    // Stage 1: differences.
    logic                         s1_valid_reg;
    logic signed [COORD_BITS-1:0] s1_ax_reg, s1_ay_reg;
    logic signed [DIFF_BITS-1:0]  s1_ux_reg, s1_uy_reg, s1_vx_reg, s1_vy_reg;
    logic signed [DIFF_BITS-1:0]  s1_wx_reg, s1_wy_reg;

    // Stage 2: products.
    logic                         s2_valid_reg;
    logic signed [COORD_BITS-1:0] s2_ax_reg, s2_ay_reg;
    logic signed [DIFF_BITS-1:0]  s2_ux_reg, s2_uy_reg;
    logic signed [PROD_BITS-1:0]  s2_p_reg [6];

    // Stage 3: cross products.
    logic                         s3_valid_reg;
    logic signed [COORD_BITS-1:0] s3_ax_reg, s3_ay_reg;
    logic signed [DIFF_BITS-1:0]  s3_ux_reg, s3_uy_reg;
    logic signed [CROSS_BITS-1:0] s3_den_reg, s3_s_reg, s3_t_reg;

    div_t out_reg;
    div_t out_next;

    function automatic logic signed [DIFF_BITS-1:0] sub_c(
        input logic [COORD_BITS-1:0] p, input logic [COORD_BITS-1:0] q);
        return {p[COORD_BITS-1], p} - {q[COORD_BITS-1], q};
    endfunction

    function automatic logic signed [CROSS_BITS-1:0] sub_p(
        input logic [PROD_BITS-1:0] p, input logic [PROD_BITS-1:0] q);
        return {p[PROD_BITS-1], p} - {q[PROD_BITS-1], q};
    endfunction

    function automatic logic inside_open(
        input logic signed [CROSS_BITS-1:0] num, input logic signed [CROSS_BITS-1:0] den);
        if (den > 0) begin
            return (num > 0) && (num < den);
        end
        return (num < 0) && (num > den);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            out_reg.valid <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            out_reg.valid <= s3_valid_reg;
        end
        if (en) begin
            s1_ax_reg <= in_pair.ax;
            s1_ay_reg <= in_pair.ay;
            s1_ux_reg <= sub_c(in_pair.bx, in_pair.ax);
            s1_uy_reg <= sub_c(in_pair.by, in_pair.ay);
            s1_vx_reg <= sub_c(in_pair.dx, in_pair.cx);
            s1_vy_reg <= sub_c(in_pair.dy, in_pair.cy);
            s1_wx_reg <= sub_c(in_pair.cx, in_pair.ax);
            s1_wy_reg <= sub_c(in_pair.cy, in_pair.ay);

            s2_ax_reg <= s1_ax_reg;
            s2_ay_reg <= s1_ay_reg;
            s2_ux_reg <= s1_ux_reg;
            s2_uy_reg <= s1_uy_reg;
            s2_p_reg[0] <= s1_ux_reg * s1_vy_reg;
            s2_p_reg[1] <= s1_uy_reg * s1_vx_reg;
            s2_p_reg[2] <= s1_wx_reg * s1_vy_reg;
            s2_p_reg[3] <= s1_wy_reg * s1_vx_reg;
            s2_p_reg[4] <= s1_wx_reg * s1_uy_reg;
            s2_p_reg[5] <= s1_wy_reg * s1_ux_reg;

            s3_ax_reg  <= s2_ax_reg;
            s3_ay_reg  <= s2_ay_reg;
            s3_ux_reg  <= s2_ux_reg;
            s3_uy_reg  <= s2_uy_reg;
            s3_den_reg <= sub_p(s2_p_reg[0], s2_p_reg[1]);
            s3_s_reg   <= sub_p(s2_p_reg[2], s2_p_reg[3]);
            s3_t_reg   <= sub_p(s2_p_reg[4], s2_p_reg[5]);

            out_reg.hit <= out_next.hit;
            out_reg.par <= out_next.par;
            out_reg.ax  <= out_next.ax;
            out_reg.ay  <= out_next.ay;
            out_reg.ux  <= out_next.ux;
            out_reg.uy  <= out_next.uy;
            out_reg.rem <= out_next.rem;
            out_reg.den <= out_next.den;
            out_reg.quo <= out_next.quo;
        end
    end

    always_comb begin
        out_next       = out_reg;
        out_next.valid = s3_valid_reg;
        out_next.par   = (s3_den_reg == '0);
        out_next.hit   = !out_next.par && inside_open(s3_s_reg, s3_den_reg)
                         && inside_open(s3_t_reg, s3_den_reg);
        out_next.ax    = s3_ax_reg;
        out_next.ay    = s3_ay_reg;
        out_next.ux    = s3_ux_reg;
        out_next.uy    = s3_uy_reg;
        out_next.rem   = s3_s_reg[CROSS_BITS-1] ? CROSS_BITS'(-s3_s_reg)
                                                : CROSS_BITS'(s3_s_reg);
        out_next.den   = s3_den_reg[CROSS_BITS-1] ? CROSS_BITS'(-s3_den_reg)
                                                  : CROSS_BITS'(s3_den_reg);
        out_next.quo   = '0;
    end

    assign out_div = out_reg;

endmodule

// ===== rtl/core/segx_div_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segx_div_stage
// One restoring division step: one quotient bit per register stage.
// ----------------------------------------------------------------------------
module segx_div_stage
    import segx_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic en,
    input  div_t in_div,
    output div_t out_div
);

    div_t                  out_reg;
    div_t                  out_next;
    logic [CROSS_BITS:0]   trial;
    logic [CROSS_BITS:0]   shifted;

    always_comb begin
        out_next = in_div;
        shifted  = {in_div.rem, 1'b0};
        trial    = shifted - {1'b0, in_div.den};
        // For a hit the remainder stays below the divisor, so it fits after the step.
        if (shifted >= {1'b0, in_div.den}) begin
            out_next.rem = trial[CROSS_BITS-1:0];
            out_next.quo = {in_div.quo[FRAC_BITS-2:0], 1'b1};
        end else begin
            out_next.rem = shifted[CROSS_BITS-1:0];
            out_next.quo = {in_div.quo[FRAC_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_reg.valid <= 1'b0;
        end else if (en) begin
            out_reg.valid <= out_next.valid;
        end
        if (en) begin
            out_reg.hit <= out_next.hit;
            out_reg.par <= out_next.par;
            out_reg.ax  <= out_next.ax;
            out_reg.ay  <= out_next.ay;
            out_reg.ux  <= out_next.ux;
            out_reg.uy  <= out_next.uy;
            out_reg.rem <= out_next.rem;
            out_reg.den <= out_next.den;
            out_reg.quo <= out_next.quo;
        end
    end

    assign out_div = out_reg;

endmodule

// ===== rtl/core/segx_point.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segx_point
// Scales the direction of AB by the quotient, adds the start point and holds
// the result, or zero without a hit, in the output register.
// ----------------------------------------------------------------------------
module segx_point
    import segx_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  div_t                         in_div,
    output logic                         out_valid,
    output logic                         out_hit,
    output logic                         out_par,
    output logic signed [POINT_BITS-1:0] out_x,
    output logic signed [POINT_BITS-1:0] out_y
);

    logic                         m_valid_reg, m_hit_reg, m_par_reg;
    logic signed [COORD_BITS-1:0] m_ax_reg, m_ay_reg;
    logic signed [MUL_BITS-1:0]   m_px_reg, m_py_reg;
    logic signed [FRAC_BITS:0]    quo_s;

    logic                         o_valid_reg, o_hit_reg, o_par_reg;
    logic signed [POINT_BITS-1:0] o_x_reg, o_y_reg;
    logic [POINT_BITS-1:0]        x_next, y_next;

    assign quo_s = signed'({1'b0, in_div.quo});

    always_comb begin
        x_next = (POINT_BITS'(m_ax_reg) << FRAC_BITS) + POINT_BITS'(m_px_reg);
        y_next = (POINT_BITS'(m_ay_reg) << FRAC_BITS) + POINT_BITS'(m_py_reg);
        if (!m_hit_reg) begin
            x_next = '0;
            y_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= in_div.valid;
            o_valid_reg <= m_valid_reg;
        end
        if (en) begin
            m_hit_reg <= in_div.hit;
            m_par_reg <= in_div.par;
            m_ax_reg  <= in_div.ax;
            m_ay_reg  <= in_div.ay;
            m_px_reg  <= in_div.ux * quo_s;
            m_py_reg  <= in_div.uy * quo_s;
            o_hit_reg <= m_hit_reg;
            o_par_reg <= m_par_reg;
            o_x_reg   <= signed'(x_next);
            o_y_reg   <= signed'(y_next);
        end
    end

    assign out_valid = o_valid_reg;
    assign out_hit   = o_hit_reg;
    assign out_par   = o_par_reg;
    assign out_x     = o_x_reg;
    assign out_y     = o_y_reg;

endmodule

// ===== dv/segment_intersection_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_intersection_unit_tb
// Self-checking bench for the segment intersection unit.
// ----------------------------------------------------------------------------
// Segment pairs are queued by a stimulus process, driven by a clocked driver
// and checked against an exact integer computation of the crossing test and
// the Q16.16 crossing point. Both stream sides stall at random in all but the last phase.
module segment_intersection_unit_tb;
    import segx_pkg::*;

    localparam int LATENCY   = FRAC_BITS + 6;
    localparam int WDOG_MAX  = 20000;

    typedef struct packed {
        logic        hit;
        logic        par;
        logic [31:0] px;
        logic [31:0] py;
    } crossing_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [8*IN_BYTES-1:0] s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [63:0]           m_tdata;
    logic [1:0]            m_tuser;

    seg_pair_t pending_pairs[$];
    crossing_t expected_crossings[$];
    int        send_idle_pct;
    int        recv_idle_pct;
    int        hold_off_cycles;
    int        error_count;
    int        accepted_pairs;
    int        checked_results;
    int        hit_count;
    int        par_count;
    int        idle_cycles;

    segment_intersection_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic crossing_t predict_crossing(seg_pair_t p);
        longint    ux, uy, vx, vy, wx, wy, den, s, t, as, ad, q;
        bit        s_in, t_in;
        crossing_t r;
        ux = longint'(p.bx) - longint'(p.ax);
        uy = longint'(p.by) - longint'(p.ay);
        vx = longint'(p.dx) - longint'(p.cx);
        vy = longint'(p.dy) - longint'(p.cy);
        wx = longint'(p.cx) - longint'(p.ax);
        wy = longint'(p.cy) - longint'(p.ay);
        den = ux * vy - uy * vx;
        s = wx * vy - wy * vx;
        t = wx * uy - wy * ux;
        r = '0;
        if (den == 0) begin
            r.par = 1'b1;
        end else begin
            s_in = (den > 0) ? (s > 0 && s < den) : (s < 0 && s > den);
            t_in = (den > 0) ? (t > 0 && t < den) : (t < 0 && t > den);
            if (s_in && t_in) begin
                as = (s < 0) ? -s : s;
                ad = (den < 0) ? -den : den;
                q = (as <<< FRAC_BITS) / ad;
                r.hit = 1'b1;
                r.px = 32'((longint'(p.ax) <<< FRAC_BITS) + ux * q);
                r.py = 32'((longint'(p.ay) <<< FRAC_BITS) + uy * q);
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("Mismatch on result %0d: %s got %h, expected %h",
                 checked_results, what, got, want);
        error_count++;
    endtask

    // Driver: a new item is only presented once the previous one has gone.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pending_pairs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_pairs.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Prediction at each accepted input transfer.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            expected_crossings.push_back(predict_crossing(seg_pair_t'(s_tdata)));
            accepted_pairs++;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            m_tready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor and checker.
    always @(posedge aclk) begin
        crossing_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_crossings.size() == 0) begin
                $display("Unexpected result transfer: %h %h", m_tuser, m_tdata);
                error_count++;
            end else begin
                want = expected_crossings.pop_front();
                if (m_tuser[0] !== want.hit)
                    report_mismatch("hit", 32'(m_tuser[0]), 32'(want.hit));
                if (m_tuser[1] !== want.par)
                    report_mismatch("parallel", 32'(m_tuser[1]), 32'(want.par));
                if (m_tdata[31:0] !== want.px)
                    report_mismatch("point_x", m_tdata[31:0], want.px);
                if (m_tdata[63:32] !== want.py)
                    report_mismatch("point_y", m_tdata[63:32], want.py);
                hit_count += want.hit;
                par_count += want.par;
            end
            checked_results++;
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WDOG_MAX) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    function automatic int rand_coord(int span);
        if (span == 0)
            return int'($urandom_range(65535));
        return int'($urandom_range(2 * span)) - span;
    endfunction

    function automatic seg_pair_t make_pair(int ax, int ay, int bx, int by,
            int cx, int cy, int dx, int dy);
        seg_pair_t p;
        p.ax = 16'(ax);
        p.ay = 16'(ay);
        p.bx = 16'(bx);
        p.by = 16'(by);
        p.cx = 16'(cx);
        p.cy = 16'(cy);
        p.dx = 16'(dx);
        p.dy = 16'(dy);
        return p;
    endfunction

    // Mostly crossing pairs: CD mirrored around the midpoint M of AB, so both pass through M.
    task automatic queue_random(int n);
        seg_pair_t p;
        int        span, mx, my, kind;
        for (int i = 0; i < n; i++) begin
            kind = $urandom_range(9);
            span = ($urandom_range(3) == 0) ? 0 : (1 << $urandom_range(3, 14));
            p = make_pair(rand_coord(span), rand_coord(span), rand_coord(span),
                          rand_coord(span), rand_coord(span), rand_coord(span),
                          rand_coord(span), rand_coord(span));
            if (kind < 6) begin
                // C and D mirrored around a point on AB, so the pair tends to cross
                mx = (int'(p.ax) + int'(p.bx)) / 2;
                my = (int'(p.ay) + int'(p.by)) / 2;
                p.dx = 16'(2 * mx - int'(p.cx));
                p.dy = 16'(2 * my - int'(p.cy));
            end else if (kind == 6) begin
                // CD parallel to AB
                p.dx = 16'(int'(p.cx) + int'(p.bx) - int'(p.ax));
                p.dy = 16'(int'(p.cy) + int'(p.by) - int'(p.ay));
            end else if (kind == 7) begin
                // C on an endpoint of AB
                p.cx = p.bx;
                p.cy = p.by;
            end
            pending_pairs.push_back(p);
        end
    endtask

    task automatic wait_drained();
        while (pending_pairs.size() > 0 || s_tvalid || expected_crossings.size() > 0)
            @(posedge aclk);
    endtask

    initial begin
        aresetn = 1'b0;
        send_idle_pct = 33;
        recv_idle_pct = 49;
        hold_off_cycles = 0;
        error_count = 0;
        accepted_pairs = 0;
        checked_results = 0;
        hit_count = 0;
        par_count = 0;
        idle_cycles = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: crossings, touching endpoints, parallel, degenerate, extremes.
        pending_pairs.push_back(make_pair(0, 0, 16, 16, 0, 16, 16, 0));
        pending_pairs.push_back(make_pair(0, 0, 3, 0, 1, -1, 1, 2));
        pending_pairs.push_back(make_pair(0, 0, 10, 0, 0, 0, 0, 10));
        pending_pairs.push_back(make_pair(0, 0, 10, 0, 10, 0, 10, 5));
        pending_pairs.push_back(make_pair(0, 0, 10, 0, 5, 0, 5, 5));
        pending_pairs.push_back(make_pair(0, 0, 10, 10, 2, 2, 7, 7));
        pending_pairs.push_back(make_pair(0, 0, 10, 0, 0, 3, 10, 3));
        pending_pairs.push_back(make_pair(5, 5, 5, 5, 0, 0, 9, 9));
        pending_pairs.push_back(make_pair(1, 1, 1, 1, 1, 1, 1, 1));
        pending_pairs.push_back(make_pair(0, 0, 3, 0, 5, -1, 5, 1));
        pending_pairs.push_back(make_pair(16'h8000, 16'h8000, 16'h7fff, 16'h7fff,
                                          16'h8000, 16'h7fff, 16'h7fff, 16'h8000));
        pending_pairs.push_back(make_pair(16'h7fff, 16'h8000, 16'h8000, 16'h7fff,
                                          16'h8000, 16'h8000, 16'h7fff, 16'h7fff));
        pending_pairs.push_back(make_pair(16'h8000, 0, 16'h7fff, 1, 0, 16'h8000,
                                          1, 16'h7fff));
        pending_pairs.push_back(make_pair(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                          16'h8000, 16'h8000, 16'h8000, 16'h8000));
        pending_pairs.push_back(make_pair(16'hffff, 16'hffff, 16'h7fff, 16'h7fff,
                                          16'h7fff, 16'hffff, 16'hffff, 16'h7fff));
        pending_pairs.push_back(make_pair(0, 0, 3, 1, 1, 0, 2, 1));
        pending_pairs.push_back(make_pair(10, -7, -3, 20, -9, 4, 13, 2));
        wait_drained();

        // Long receiver hold-off while the sender keeps offering pairs.
        hold_off_cycles = 300;
        queue_random(200);
        wait_drained();

        queue_random(550);
        wait_drained();
        send_idle_pct = 49;
        recv_idle_pct = 33;
        queue_random(600);
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(600);
        wait_drained();
        repeat (LATENCY + 8) @(posedge aclk);

        $display("Checked %0d of %0d segment pairs: %0d crossings, %0d parallel.",
                 checked_results, accepted_pairs, hit_count, par_count);
        $display("Stall phases, a long output hold-off and full-rate streaming were run.");
        if (error_count == 0 && expected_crossings.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== segment_intersection_unit.f =====
rtl/core/segx_pkg.sv
rtl/core/segx_cross.sv
rtl/core/segx_div_stage.sv
rtl/core/segx_point.sv
rtl/core/segment_intersection_unit.sv
dv/segment_intersection_unit_tb.sv
